>>> rtl/core/fasd_pkg.sv
`timescale 1ns / 1ps

package fasd_pkg;

    localparam int FRAME_BITS_DEFAULT = 24;
    localparam int SUM_BITS_DEFAULT   = 40;

    localparam int GREEN_BITS = 16;
    localparam int PAD_BITS   = 8;
    localparam int CFG_INDEX_BITS = 3;

    // Register reset values
    localparam int SUM_THRESHOLD_RESET = 0;
    localparam int GAP_FRAMES_RESET    = 150;
    localparam int PAD_FRAMES_RESET    = 30;
    localparam int TOTAL_FRAMES_RESET  = 0;
    localparam int REPORT_ENABLE_RESET = 1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SUM_THRESHOLD = 3'd0,
        REG_GAP_FRAMES    = 3'd1,
        REG_PAD_FRAMES    = 3'd2,
        REG_TOTAL_FRAMES  = 3'd3,
        REG_REPORT_ENABLE = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } func_t;

endpackage

>>> rtl/core/frame_activity_segment_detector.sv
`timescale 1ns / 1ps
// A result appears on out_valid in the cycle after the transaction that causes it.
// Throughput: one transaction per cycle; the input stalls only while a result is held
// by out_stall, since a single output register separates the two sides.
// Per-pixel path is one saturating accumulate; frame end adds one compare and update.
// Reset (rst_n low, asynchronous) clears the output valid and the frame state and
// loads the register defaults: threshold 0, gap 150, pad 30, total 0, report on.
module frame_activity_segment_detector
#(
    parameter int FRAME_BITS = fasd_pkg::FRAME_BITS_DEFAULT,
    parameter int SUM_BITS   = fasd_pkg::SUM_BITS_DEFAULT,
    localparam int CFG_BITS  = (SUM_BITS > FRAME_BITS) ? SUM_BITS : FRAME_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [fasd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [fasd_pkg::GREEN_BITS-1:0]     green,
    input  logic                                frame_last,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                keep,
    output logic                                seg_valid,
    output logic [FRAME_BITS-1:0]               seg_first,
    output logic [FRAME_BITS-1:0]               seg_last,
    output logic                                is_flush
);
    import fasd_pkg::*;

    // configuration
    logic [SUM_BITS-1:0]   sum_threshold_reg;
    logic [FRAME_BITS-1:0] gap_frames_reg;
    logic [PAD_BITS-1:0]   pad_frames_reg;
    logic [FRAME_BITS-1:0] total_frames_reg;
    logic                  report_enable_reg;

    // frame state
    logic [SUM_BITS-1:0]   green_sum_reg,   green_sum_next;
    logic [FRAME_BITS-1:0] frame_index_reg, frame_index_next;
    logic                  keeping_reg,     keeping_next;
    logic [FRAME_BITS-1:0] open_start_reg,  open_start_next;
    logic [FRAME_BITS-1:0] last_end_reg,    last_end_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    logic                  keep_reg,      keep_next;
    logic                  seg_valid_reg, seg_valid_next;
    logic [FRAME_BITS-1:0] seg_first_reg, seg_first_next;
    logic [FRAME_BITS-1:0] seg_last_reg,  seg_last_next;
    logic                  is_flush_reg,  is_flush_next;

    logic in_accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_threshold_reg <= SUM_BITS'(SUM_THRESHOLD_RESET);
            gap_frames_reg    <= FRAME_BITS'(GAP_FRAMES_RESET);
            pad_frames_reg    <= PAD_BITS'(PAD_FRAMES_RESET);
            total_frames_reg  <= FRAME_BITS'(TOTAL_FRAMES_RESET);
            report_enable_reg <= 1'(REPORT_ENABLE_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SUM_THRESHOLD: sum_threshold_reg <= cfg_data[SUM_BITS-1:0];
                REG_GAP_FRAMES:    gap_frames_reg    <= cfg_data[FRAME_BITS-1:0];
                REG_PAD_FRAMES:    pad_frames_reg    <= cfg_data[PAD_BITS-1:0];
                REG_TOTAL_FRAMES:  total_frames_reg  <= cfg_data[FRAME_BITS-1:0];
                REG_REPORT_ENABLE: report_enable_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        logic [SUM_BITS:0]     sum_ext;
        logic [SUM_BITS-1:0]   sum_sat;
        logic [FRAME_BITS-1:0] pad_ext;
        logic [FRAME_BITS:0]   end_padded;
        logic [FRAME_BITS-1:0] seg_len;
        logic [FRAME_BITS-1:0] seg_start;
        logic [FRAME_BITS-1:0] seg_end;
        logic                  far_enough;
        logic                  report;
        logic [FRAME_BITS-1:0] rep_first;
        logic [FRAME_BITS-1:0] rep_last;

        green_sum_next   = green_sum_reg;
        frame_index_next = frame_index_reg;
        keeping_next     = keeping_reg;
        open_start_next  = open_start_reg;
        last_end_next    = last_end_reg;

        out_valid_next = out_valid_reg && out_stall;
        keep_next      = keep_reg;
        seg_valid_next = seg_valid_reg;
        seg_first_next = seg_first_reg;
        seg_last_next  = seg_last_reg;
        is_flush_next  = is_flush_reg;

        sum_ext = {1'b0, green_sum_reg} + (SUM_BITS+1)'(green);
        sum_sat = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];

        pad_ext    = FRAME_BITS'(pad_frames_reg);
        end_padded = {1'b0, frame_index_reg} + {1'b0, pad_ext};
        seg_len    = (frame_index_reg >= open_start_reg) ?
                     frame_index_reg - open_start_reg : '0;
        seg_start  = (open_start_reg > pad_ext) ? open_start_reg - pad_ext : '0;
        seg_end    = (end_padded < {1'b0, total_frames_reg}) ?
                     end_padded[FRAME_BITS-1:0] : frame_index_reg;
        far_enough = (frame_index_reg > last_end_reg) &&
                     ((frame_index_reg - last_end_reg) > gap_frames_reg);

        report    = 1'b0;
        rep_first = '0;
        rep_last  = '0;

        if (in_accept)
        begin
            if (func_t'(func) == FUNC_FLUSH)
            begin
                report         = !keeping_reg;
                rep_first      = open_start_reg;
                rep_last       = total_frames_reg;
                out_valid_next = 1'b1;
                keep_next      = keeping_reg;
                is_flush_next  = 1'b1;
                keeping_next    = 1'b1;
                open_start_next = '0;
                last_end_next   = '0;
                green_sum_next  = '0;
            end
            else if (!frame_last)
            begin
                green_sum_next = sum_sat;
                out_valid_next = 1'b0;
            end
            else
            begin
                if (sum_sat > sum_threshold_reg)
                begin
                    // active frame: close the segment once it is long enough
                    if (!keeping_reg && seg_len >= gap_frames_reg)
                    begin
                        keeping_next    = 1'b1;
                        last_end_next   = seg_end;
                        open_start_next = '0;
                        report          = 1'b1;
                        rep_first       = seg_start;
                        rep_last        = seg_end;
                    end
                end
                else if (keeping_reg)
                begin
                    if (frame_index_reg == '0 || far_enough)
                    begin
                        keeping_next    = 1'b0;
                        open_start_next = frame_index_reg;
                        last_end_next   = '0;
                    end
                    else
                    begin
                        open_start_next = '0;
                    end
                end
                out_valid_next = 1'b1;
                keep_next      = keeping_next;
                is_flush_next  = 1'b0;
                green_sum_next = '0;
                if (frame_index_reg != {FRAME_BITS{1'b1}})
                begin
                    frame_index_next = frame_index_reg + FRAME_BITS'(1);
                end
            end

            if (out_valid_next)
            begin
                seg_valid_next = report && report_enable_reg;
                seg_first_next = seg_valid_next ? rep_first : '0;
                seg_last_next  = seg_valid_next ? rep_last : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_sum_reg   <= '0;
            frame_index_reg <= '0;
            keeping_reg     <= 1'b1;
            open_start_reg  <= '0;
            last_end_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            green_sum_reg   <= green_sum_next;
            frame_index_reg <= frame_index_next;
            keeping_reg     <= keeping_next;
            open_start_reg  <= open_start_next;
            last_end_reg    <= last_end_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload of the result register
    always_ff @(posedge clk)
    begin
        keep_reg      <= keep_next;
        seg_valid_reg <= seg_valid_next;
        seg_first_reg <= seg_first_next;
        seg_last_reg  <= seg_last_next;
        is_flush_reg  <= is_flush_next;
    end

    assign out_valid = out_valid_reg;
    assign keep      = keep_reg;
    assign seg_valid = seg_valid_reg;
    assign seg_first = seg_first_reg;
    assign seg_last  = seg_last_reg;
    assign is_flush  = is_flush_reg;

    // a flush transaction leaves a clean store
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && func |=> keeping_reg && open_start_reg == '0 && last_end_reg == '0
                               && green_sum_reg == '0)
        else $error("flush did not clear segment state");

    // frame counter only moves forward
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> frame_index_reg >= $past(frame_index_reg))
        else $error("frame index went backward");

    // an open segment never starts after the current frame
    assert property (@(posedge clk) disable iff (!rst_n)
        !keeping_reg |-> open_start_reg <= frame_index_reg)
        else $error("open segment starts beyond frame index");

    // a reported segment from a frame end is kept, from a flush it is not
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && seg_valid_reg |-> keep_reg != is_flush_reg)
        else $error("keep flag inconsistent with reported segment");

    // padded frame-end segments are ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && seg_valid_reg && !is_flush_reg |-> seg_first_reg <= seg_last_reg)
        else $error("reported segment ends before it starts");

endmodule
